FILE: sv/plnh_pkg.sv
package plnh_pkg;

    // field widths of the beats
    localparam int unsigned ANGLE_BITS = 16;
    localparam int unsigned GRAD_BITS  = 32;
    localparam int unsigned HAM_BITS   = 48;
    localparam int unsigned CFG_BITS   = 16;

    // cordic: 2^32 per turn, x/y held in Q2.30, z in those turn units
    localparam int unsigned TURN_BITS    = 32;
    localparam int unsigned CORDIC_W     = 32;
    localparam int unsigned CORDIC_STEPS = 24;
    localparam int unsigned TRIG_BITS    = CORDIC_W - 16;
    // capture stage, one stage per rotation, rounding/quadrant stage
    localparam int unsigned CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic signed [HAM_BITS-1:0] HAM_MAX = {1'b0, {(HAM_BITS-1){1'b1}}};
    localparam logic signed [HAM_BITS-1:0] HAM_MIN = {1'b1, {(HAM_BITS-1){1'b0}}};

    localparam int unsigned CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SPEED_MIN      = 3'd0,
        CFG_SPEED_MAX      = 3'd1,
        CFG_TURN_RATE_MAX  = 3'd2,
        CFG_DIST_BOUND_X   = 3'd3,
        CFG_DIST_BOUND_Y   = 3'd4,
        CFG_CTRL_MAXIMIZES = 3'd5,
        CFG_DIST_MINIMIZES = 3'd6,
        CFG_BACKWARD_REACH = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] grad_x;
        logic signed [GRAD_BITS-1:0] grad_y;
        logic signed [GRAD_BITS-1:0] grad_heading;
        logic        [ANGLE_BITS-1:0] heading;
        logic                         in_active_set;
        logic                         chunk_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [HAM_BITS-1:0] ham_value;
        logic                       chunk_end_out;
    } t_out_beat;

    // per-point tag carried beside the arithmetic
    typedef struct packed {
        logic active;
        logic chunk_end;
    } t_tag;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic signed [CORDIC_W-1:0] cordic_angle(input int unsigned idx);
        logic signed [CORDIC_W-1:0] a;
        case (idx)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458907;
            3:       a = 32'sd85004756;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10679838;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10430;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            20:      a = 32'sd652;
            21:      a = 32'sd326;
            22:      a = 32'sd163;
            23:      a = 32'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: sv/plnh_cordic.sv
module plnh_cordic
    import plnh_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ANGLE_BITS-1:0]       i_angle,
    output logic signed [TRIG_BITS-1:0] o_cos,
    output logic signed [TRIG_BITS-1:0] o_sin
);

    localparam logic signed [CORDIC_W-1:0] RND_HALF = CORDIC_W'(32768);

    logic [TURN_BITS-1:0] w_turn;

    logic signed [CORDIC_W-1:0] r_x [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] r_y [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] r_z [CORDIC_STEPS+1];
    logic [1:0]                 r_q [CORDIC_STEPS+1];

    logic signed [CORDIC_W-1:0]  w_xr;
    logic signed [CORDIC_W-1:0]  w_yr;
    logic signed [TRIG_BITS-1:0] w_cx;
    logic signed [TRIG_BITS-1:0] w_sy;
    logic signed [TRIG_BITS-1:0] n_cos;
    logic signed [TRIG_BITS-1:0] n_sin;
    logic signed [TRIG_BITS-1:0] r_cos;
    logic signed [TRIG_BITS-1:0] r_sin;

    assign w_turn = {i_angle, {(TURN_BITS-ANGLE_BITS){1'b0}}};

    // capture: quadrant split off, remaining angle into z
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= CORDIC_W'({2'b00, w_turn[TURN_BITS-3:0]});
            r_q[0] <= w_turn[TURN_BITS-1:TURN_BITS-2];
        end
    end

    // one rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][CORDIC_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - cordic_angle(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + cordic_angle(i);
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    // round Q2.30 to Q2.14, then fold in the quadrant
    always_comb begin
        w_xr = r_x[CORDIC_STEPS] + RND_HALF;
        w_yr = r_y[CORDIC_STEPS] + RND_HALF;
        w_cx = w_xr[CORDIC_W-1:CORDIC_W-TRIG_BITS];
        w_sy = w_yr[CORDIC_W-1:CORDIC_W-TRIG_BITS];
        case (r_q[CORDIC_STEPS])
            2'd0: begin
                n_cos = w_cx;
                n_sin = w_sy;
            end
            2'd1: begin
                n_cos = -w_sy;
                n_sin = w_cx;
            end
            2'd2: begin
                n_cos = -w_cx;
                n_sin = -w_sy;
            end
            default: begin
                n_cos = w_sy;
                n_sin = -w_cx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

FILE: sv/plane_hamiltonian_point.sv
// channel  | direction | signals                                    | beat
// ---------+-----------+--------------------------------------------+-----------------------
// in       | sink      | i_in_valid, o_in_ready, i_in_beat          | t_in_beat, one point
// out      | source    | o_out_valid, i_out_ready, o_out_beat       | t_out_beat, one result
// cfg      | sink      | i_cfg_valid, o_cfg_ready, i_cfg_index/data | one register write
//
// one point per cycle while the skid is empty; registers from input beat to output beat:
// 26 in the cordic (capture, 24 rotations, round/quadrant), 5 arithmetic stages, output reg.
// the whole pipeline advances together while the output skid register is empty; a stall
// at the output parks one result in the skid and freezes every stage, nothing is lost.
// synchronous active-low reset clears valid bits and loads the register defaults. configuration
// writes are always taken and reach every stage at once; the user must keep the pipe empty for them, unchecked.
module plane_hamiltonian_point
    import plnh_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // point input
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_in_beat                  i_in_beat,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_out_beat                 o_out_beat,
    // register writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]       i_cfg_data
);

    // product width of a gradient times a 16 bit factor
    localparam int unsigned PW   = GRAD_BITS + 16;
    // Q16.16 terms after dropping 8 fraction bits
    localparam int unsigned RW   = PW - 7;
    // magnitude of s after rounding to Q16.16
    localparam int unsigned SMW  = PW - 12;
    // speed product and its rounded form
    localparam int unsigned SPW  = SMW + 16;
    localparam int unsigned SPRW = SPW - 7;
    // signed accumulator
    localparam int unsigned SUMW = PW + 2;

    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(HAM_MAX);
    localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(HAM_MIN);

    // ---------------- configuration registers ----------------
    logic signed [CFG_BITS-1:0] r_speed_min;
    logic signed [CFG_BITS-1:0] r_speed_max;
    logic [CFG_BITS-1:0]        r_turn_rate_max;
    logic [CFG_BITS-1:0]        r_dist_bound_x;
    logic [CFG_BITS-1:0]        r_dist_bound_y;
    logic                       r_ctrl_max;
    logic                       r_dist_min;
    logic                       r_backward;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_min     <= CFG_BITS'(256);
            r_speed_max     <= CFG_BITS'(256);
            r_turn_rate_max <= CFG_BITS'(256);
            r_dist_bound_x  <= '0;
            r_dist_bound_y  <= '0;
            r_ctrl_max      <= 1'b1;
            r_dist_min      <= 1'b1;
            r_backward      <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SPEED_MIN:      r_speed_min     <= i_cfg_data;
                CFG_SPEED_MAX:      r_speed_max     <= i_cfg_data;
                CFG_TURN_RATE_MAX:  r_turn_rate_max <= i_cfg_data;
                CFG_DIST_BOUND_X:   r_dist_bound_x  <= i_cfg_data;
                CFG_DIST_BOUND_Y:   r_dist_bound_y  <= i_cfg_data;
                CFG_CTRL_MAXIMIZES: r_ctrl_max      <= i_cfg_data[0];
                CFG_DIST_MINIMIZES: r_dist_min      <= i_cfg_data[0];
                CFG_BACKWARD_REACH: r_backward      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    logic r_skid_v;
    logic w_adv;

    // every stage moves while the skid slot is free
    assign w_adv      = !r_skid_v;
    assign o_in_ready = w_adv;

    // ---------------- cordic and its sideband ----------------
    logic signed [TRIG_BITS-1:0] w_cos;
    logic signed [TRIG_BITS-1:0] w_sin;

    plnh_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (i_in_beat.heading),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    logic     r_sv [CORDIC_LAT];
    t_in_beat r_sb [CORDIC_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_LAT; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_sv[0] <= i_in_valid;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sb[0] <= i_in_beat;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // ---------------- stage a: products ----------------
    t_in_beat             w_pt;
    logic [GRAD_BITS-1:0] w_gx_mag;
    logic [GRAD_BITS-1:0] w_gy_mag;
    logic [GRAD_BITS-1:0] w_gh_mag;

    assign w_pt = r_sb[CORDIC_LAT-1];

    // magnitudes; the most negative value maps onto its unsigned pattern
    always_comb begin
        w_gx_mag = w_pt.grad_x[GRAD_BITS-1] ? GRAD_BITS'(-w_pt.grad_x)
                                            : GRAD_BITS'(w_pt.grad_x);
        w_gy_mag = w_pt.grad_y[GRAD_BITS-1] ? GRAD_BITS'(-w_pt.grad_y)
                                            : GRAD_BITS'(w_pt.grad_y);
        w_gh_mag = w_pt.grad_heading[GRAD_BITS-1] ? GRAD_BITS'(-w_pt.grad_heading)
                                                  : GRAD_BITS'(w_pt.grad_heading);
    end

    logic               r_a_v;
    t_tag               r_a_tag;
    logic signed [PW-1:0] r_a_px;
    logic signed [PW-1:0] r_a_py;
    logic [PW-1:0]      r_a_tn;
    logic [PW-1:0]      r_a_dx;
    logic [PW-1:0]      r_a_dy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_tag <= '{active: w_pt.in_active_set, chunk_end: w_pt.chunk_end};
            r_a_px  <= PW'(w_pt.grad_x) * PW'(w_cos);
            r_a_py  <= PW'(w_pt.grad_y) * PW'(w_sin);
            r_a_tn  <= PW'(r_turn_rate_max) * PW'(w_gh_mag);
            r_a_dx  <= PW'(r_dist_bound_x) * PW'(w_gx_mag);
            r_a_dy  <= PW'(r_dist_bound_y) * PW'(w_gy_mag);
        end
    end

    // ---------------- stage b: s at Q.30, round the bound terms ----------------
    logic [PW:0] w_tn_r;
    logic [PW:0] w_dx_r;
    logic [PW:0] w_dy_r;

    always_comb begin
        w_tn_r = {1'b0, r_a_tn} + (PW+1)'(128);
        w_dx_r = {1'b0, r_a_dx} + (PW+1)'(128);
        w_dy_r = {1'b0, r_a_dy} + (PW+1)'(128);
    end

    logic                 r_b_v;
    t_tag                 r_b_tag;
    logic signed [PW:0]   r_b_s;
    logic [RW-1:0]        r_b_tn;
    logic [RW-1:0]        r_b_dx;
    logic [RW-1:0]        r_b_dy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_tag <= r_a_tag;
            r_b_s   <= (PW+1)'(r_a_px) + (PW+1)'(r_a_py);
            r_b_tn  <= w_tn_r[PW:8];
            r_b_dx  <= w_dx_r[PW:8];
            r_b_dy  <= w_dy_r[PW:8];
        end
    end

    // ---------------- stage c: round s to Q16.16, sum disturbance ----------------
    logic [PW:0]   w_s_mag;
    logic [PW+1:0] w_s_r;

    always_comb begin
        w_s_mag = r_b_s[PW] ? (PW+1)'(-r_b_s) : (PW+1)'(r_b_s);
        w_s_r   = {1'b0, w_s_mag} + (PW+2)'(1 << 13);
    end

    logic           r_c_v;
    t_tag           r_c_tag;
    logic           r_c_sneg;
    logic [SMW-1:0] r_c_smag;
    logic [RW-1:0]  r_c_tn;
    logic [RW:0]    r_c_dist;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_tag  <= r_b_tag;
            r_c_sneg <= r_b_s[PW];
            r_c_smag <= w_s_r[PW+1:14];
            r_c_tn   <= r_b_tn;
            r_c_dist <= (RW+1)'(r_b_dx) + (RW+1)'(r_b_dy);
        end
    end

    // ---------------- stage d: speed product ----------------
    logic                       w_use_max;
    logic signed [CFG_BITS-1:0] w_speed;
    logic [CFG_BITS-1:0]        w_speed_mag;

    always_comb begin
        // zero counts as non-negative
        w_use_max   = r_ctrl_max ? !r_c_sneg : r_c_sneg;
        w_speed     = w_use_max ? r_speed_max : r_speed_min;
        w_speed_mag = w_speed[CFG_BITS-1] ? CFG_BITS'(-w_speed) : CFG_BITS'(w_speed);
    end

    logic           r_d_v;
    t_tag           r_d_tag;
    logic           r_d_spneg;
    logic [SPW-1:0] r_d_sp;
    logic [RW-1:0]  r_d_tn;
    logic [RW:0]    r_d_dist;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_tag   <= r_c_tag;
            r_d_spneg <= r_c_sneg ^ w_speed[CFG_BITS-1];
            r_d_sp    <= SPW'(r_c_smag) * SPW'(w_speed_mag);
            r_d_tn    <= r_c_tn;
            r_d_dist  <= r_c_dist;
        end
    end

    // ---------------- stage e: signed sum of the three terms ----------------
    logic [SPW:0]            w_sp_r;
    logic [SPRW-1:0]         w_sp_rnd;
    logic signed [SUMW-1:0]  w_t_sp;
    logic signed [SUMW-1:0]  w_t_tn;
    logic signed [SUMW-1:0]  w_t_ds;

    always_comb begin
        w_sp_r   = {1'b0, r_d_sp} + (SPW+1)'(128);
        w_sp_rnd = w_sp_r[SPW:8];
        w_t_sp   = r_d_spneg ? -SUMW'(w_sp_rnd) : SUMW'(w_sp_rnd);
        w_t_tn   = r_ctrl_max ? SUMW'(r_d_tn) : -SUMW'(r_d_tn);
        w_t_ds   = r_dist_min ? -SUMW'(r_d_dist) : SUMW'(r_d_dist);
    end

    logic                   r_e_v;
    t_tag                   r_e_tag;
    logic signed [SUMW-1:0] r_e_sum;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_tag <= r_d_tag;
            r_e_sum <= w_t_sp + w_t_tn + w_t_ds;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (w_adv) begin
            r_a_v <= r_sv[CORDIC_LAT-1];
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    // ---------------- final: direction, clamp, inactive points ----------------
    logic signed [SUMW-1:0] w_fin;
    t_out_beat              w_res;

    always_comb begin
        w_fin = r_backward ? -r_e_sum : r_e_sum;
        if (w_fin > SAT_HI) begin
            w_fin = SAT_HI;
        end else if (w_fin < SAT_LO) begin
            w_fin = SAT_LO;
        end
        w_res.ham_value     = r_e_tag.active ? w_fin[HAM_BITS-1:0] : '0;
        w_res.chunk_end_out = r_e_tag.chunk_end;
    end

    // ---------------- output register and skid ----------------
    logic      r_out_v;
    t_out_beat r_out;
    t_out_beat r_skid;
    logic      w_push;

    assign w_push = w_adv && r_e_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // pipeline frozen, drain the skid into the output reg
            if (i_out_ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_v || i_out_ready) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_out_v || i_out_ready) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_beat  = r_out;

endmodule

FILE: bench/plane_hamiltonian_point_tb.sv
`timescale 1ns / 100ps

module plane_hamiltonian_point_tb;
    import plnh_pkg::*;

    localparam int      N_DIRECTED     = 20;
    localparam int      N_PHASES       = 10;
    localparam int      PTS_PER_PHASE  = 175;
    localparam int      HOLD_AT        = 800;
    localparam int      LONG_HOLD      = 400;
    localparam int      TAIL_CYCLES    = 48;
    localparam int      WATCHDOG_LIMIT = 4000;

    localparam longint  ROT_START = 64'sd652032874;
    localparam longint  HAM_TOP   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint  HAM_BOT   = -HAM_TOP - 1;
    localparam logic signed [31:0] GMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] GMIN = 32'sh8000_0000;

    typedef struct packed {
        t_in_beat                pt;
        bit                      typed;
        logic signed [HAM_BITS-1:0] ham;
    } t_row;

    typedef struct packed {
        logic [CFG_BITS-1:0] speed_min;
        logic [CFG_BITS-1:0] speed_max;
        logic [CFG_BITS-1:0] turn_max;
        logic [CFG_BITS-1:0] dist_x;
        logic [CFG_BITS-1:0] dist_y;
        bit                  ctrl_max;
        bit                  dist_min;
        bit                  backward;
    } t_reg_set;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    t_in_beat                  i_in_beat;
    logic                      o_out_valid;
    logic                      i_out_ready;
    t_out_beat                 o_out_beat;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]       i_cfg_data;

    // shadow of the block's registers, updated on each accepted write beat
    longint                    sh_speed_min;
    longint                    sh_speed_max;
    longint unsigned           sh_turn_max;
    longint unsigned           sh_dist_x;
    longint unsigned           sh_dist_y;
    bit                        sh_ctrl_max;
    bit                        sh_dist_min;
    bit                        sh_backward;

    t_out_beat                 pending_ham [$];
    int                        err_cnt;
    int                        pts_in;
    int                        res_cnt;
    int                        cfg_cnt;
    int                        longest_hold;
    bit                        tx_steady;
    bit                        rx_steady;

    plane_hamiltonian_point i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic longint unsigned mag64(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // round to nearest, halves away from zero, on a magnitude
    function automatic longint unsigned round_off(input longint unsigned m, input int n);
        return (m + (64'd1 << (n - 1))) >> n;
    endfunction

    function automatic longint signed_mag(input longint unsigned m, input bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // hamiltonian of one grid point under the shadow registers
    function automatic t_out_beat predict_ham(input t_in_beat p);
        longint                  gx, gy, gh;
        longint                  x, y, z, dx, dy, cx, sy, c, sn;
        longint                  sfull, s16, v, sum;
        longint unsigned         m, dist_sum;
        logic [TURN_BITS-1:0]    turn;
        bit                      s_nonneg, use_max;
        t_out_beat               r;
        gx = p.grad_x;
        gy = p.grad_y;
        gh = p.grad_heading;
        r.chunk_end_out = p.chunk_end;
        r.ham_value     = '0;
        if (p.in_active_set) begin
            // heading scaled to a full 32-bit turn, top two bits are the quadrant
            turn = TURN_BITS'(p.heading) << (TURN_BITS - ANGLE_BITS);
            x = ROT_START;
            y = 0;
            z = {34'd0, turn[29:0]};
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - cordic_angle(i);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + cordic_angle(i);
                end
            end
            // down to q2.14 by floor of (v + half)
            cx = (x + 32768) >>> 16;
            sy = (y + 32768) >>> 16;
            case (turn[31:30])
                2'b00: begin c = cx;  sn = sy;  end
                2'b01: begin c = -sy; sn = cx;  end
                2'b10: begin c = -cx; sn = -sy; end
                default: begin c = sy; sn = -cx; end
            endcase
            sfull    = gx * c + gy * sn;
            s_nonneg = (sfull >= 0);
            s16      = signed_mag(round_off(mag64(sfull), 14), !s_nonneg);
            // zero counts as non-negative when picking the speed
            use_max  = sh_ctrl_max ? s_nonneg : !s_nonneg;
            v        = use_max ? sh_speed_max : sh_speed_min;
            m        = round_off(mag64(s16) * mag64(v), 8);
            sum      = signed_mag(m, (s16 < 0) != (v < 0));
            m        = round_off(sh_turn_max * mag64(gh), 8);
            sum      = sum + signed_mag(m, !sh_ctrl_max);
            dist_sum = round_off(sh_dist_x * mag64(gx), 8)
                     + round_off(sh_dist_y * mag64(gy), 8);
            sum      = sum + signed_mag(dist_sum, sh_dist_min);
            if (sh_backward)
                sum = -sum;
            if (sum > HAM_TOP)
                sum = HAM_TOP;
            if (sum < HAM_BOT)
                sum = HAM_BOT;
            r.ham_value = sum[HAM_BITS-1:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus tables

    function automatic t_row mk_row(input logic signed [31:0] gx, input logic signed [31:0] gy,
                                    input logic signed [31:0] gh, input logic [15:0] hd,
                                    input bit act, input bit ce, input bit typed,
                                    input logic signed [HAM_BITS-1:0] ham);
        t_row r;
        r.pt.grad_x        = gx;
        r.pt.grad_y        = gy;
        r.pt.grad_heading  = gh;
        r.pt.heading       = hd;
        r.pt.in_active_set = act;
        r.pt.chunk_end     = ce;
        r.typed            = typed;
        r.ham              = ham;
        return r;
    endfunction

    // directed points, run under the reset register values: with zero spatial derivatives
    // the speed term vanishes, unit turn rate passes |grad_heading| through, then negated
    function automatic t_row directed_row(input int k);
        case (k)
            0:  return mk_row(0, 0, 0, 16'h0000, 1, 0, 1, 48'sd0);
            1:  return mk_row(GMAX, GMAX, GMAX, 16'h1234, 0, 1, 1, 48'sd0);
            2:  return mk_row(GMIN, GMIN, GMIN, 16'hFFFF, 0, 0, 1, 48'sd0);
            3:  return mk_row(0, 0, 32'sd65536, 16'h1234, 1, 0, 1, -48'sd65536);
            4:  return mk_row(0, 0, GMIN, 16'hABCD, 1, 1, 1, -48'sd2147483648);
            5:  return mk_row(0, 0, GMAX, 16'h5555, 1, 0, 1, -48'sd2147483647);
            6:  return mk_row(0, 0, -32'sd1, 16'hFFFF, 1, 1, 1, -48'sd1);
            7:  return mk_row(32'sd65536, 0, 0, 16'h0000, 1, 0, 0, 0);
            8:  return mk_row(0, 32'sd65536, 0, 16'h4000, 1, 0, 0, 0);
            9:  return mk_row(32'sd65536, 32'sd65536, 0, 16'h8000, 1, 0, 0, 0);
            10: return mk_row(-32'sd65536, 32'sd65536, 32'sd100, 16'hC000, 1, 1, 0, 0);
            11: return mk_row(32'sd65536, 32'sd65536, 0, 16'h2000, 1, 0, 0, 0);
            12: return mk_row(GMAX, GMAX, GMAX, 16'h1000, 1, 0, 0, 0);
            13: return mk_row(GMIN, GMIN, GMIN, 16'hFFFF, 1, 1, 0, 0);
            14: return mk_row(GMIN, GMAX, 0, 16'h6000, 1, 0, 0, 0);
            15: return mk_row(GMAX, GMIN, GMIN, 16'hA000, 1, 0, 0, 0);
            16: return mk_row(32'sd123456, 0, -32'sd7, 16'h4000, 1, 0, 0, 0);
            17: return mk_row(-32'sd1, -32'sd1, -32'sd1, 16'h0001, 1, 1, 0, 0);
            18: return mk_row(32'sd1, 32'sd1, 32'sd1, 16'h7FFF, 1, 0, 0, 0);
            default: return mk_row(32'sh5A5A_A5A5, 32'shA5A5_5A5A, 32'sh0F0F_F0F0, 16'hE000,
                                   1, 1, 0, 0);
        endcase
    endfunction

    function automatic logic signed [31:0] moderate_grad();
        logic [31:0] r;
        r = $urandom;
        return {{12{r[19]}}, r[19:0]};
    endfunction

    function automatic logic signed [31:0] extreme_grad();
        case ($urandom_range(0, 4))
            0:       return GMAX;
            1:       return GMIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic t_in_beat random_point();
        t_in_beat    p;
        int unsigned pick;
        pick              = $urandom_range(0, 99);
        p.grad_x          = $urandom;
        p.grad_y          = $urandom;
        p.grad_heading    = $urandom;
        p.heading         = 16'($urandom);
        p.in_active_set   = ($urandom_range(0, 7) != 0);
        p.chunk_end       = ($urandom_range(0, 7) == 0);
        if (pick < 25) begin
            // moderate magnitudes, where roundings and sign choices show most
            p.grad_x       = moderate_grad();
            p.grad_y       = moderate_grad();
            p.grad_heading = moderate_grad();
        end else if (pick < 35) begin
            // axis headings with one or both spatial derivatives zero: s lands on or near zero
            p.heading = 16'($urandom_range(0, 3)) << 14;
            case ($urandom_range(0, 2))
                0:       p.grad_x = '0;
                1:       p.grad_y = '0;
                default: begin
                    p.grad_x = '0;
                    p.grad_y = '0;
                end
            endcase
        end else if (pick < 42) begin
            p.grad_x       = extreme_grad();
            p.grad_y       = extreme_grad();
            p.grad_heading = extreme_grad();
        end
        return p;
    endfunction

    function automatic logic [CFG_BITS-1:0] random_reg16();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // register settings per phase: the first three sit on the extremes
    function automatic t_reg_set phase_regs(input int ph);
        t_reg_set s;
        case (ph)
            0: s = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1};
            1: s = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0};
            2: s = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1};
            default: begin
                s.speed_min = random_reg16();
                s.speed_max = random_reg16();
                s.turn_max  = random_reg16();
                s.dist_x    = random_reg16();
                s.dist_y    = random_reg16();
                s.ctrl_max  = 1'($urandom_range(0, 1));
                s.dist_min  = 1'($urandom_range(0, 1));
                s.backward  = 1'($urandom_range(0, 1));
            end
        endcase
        return s;
    endfunction

    function automatic int pick_gap(input bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------- drivers

    // offer one point, hold it until taken, then queue its expected result
    task automatic drive_point(input t_in_beat p, input bit typed,
                               input logic signed [HAM_BITS-1:0] ham);
        int        gap;
        t_out_beat want;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        if (typed) begin
            want.ham_value     = ham;
            want.chunk_end_out = p.chunk_end;
        end else begin
            want = predict_ham(p);
        end
        pending_ham.push_back(want);
        pts_in++;
    endtask

    // one register write beat; valid stays high for a following write
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SPEED_MIN:      sh_speed_min = $signed(val);
            CFG_SPEED_MAX:      sh_speed_max = $signed(val);
            CFG_TURN_RATE_MAX:  sh_turn_max  = val;
            CFG_DIST_BOUND_X:   sh_dist_x    = val;
            CFG_DIST_BOUND_Y:   sh_dist_y    = val;
            CFG_CTRL_MAXIMIZES: sh_ctrl_max  = val[0];
            CFG_DIST_MINIMIZES: sh_dist_min  = val[0];
            CFG_BACKWARD_REACH: sh_backward  = val[0];
            default: ;
        endcase
        cfg_cnt++;
    endtask

    task automatic program_regs(input t_reg_set s);
        write_reg(CFG_SPEED_MIN, s.speed_min);
        write_reg(CFG_SPEED_MAX, s.speed_max);
        write_reg(CFG_TURN_RATE_MAX, s.turn_max);
        write_reg(CFG_DIST_BOUND_X, s.dist_x);
        write_reg(CFG_DIST_BOUND_Y, s.dist_y);
        write_reg(CFG_CTRL_MAXIMIZES, {15'd0, s.ctrl_max});
        write_reg(CFG_DIST_MINIMIZES, {15'd0, s.dist_min});
        write_reg(CFG_BACKWARD_REACH, {15'd0, s.backward});
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering and let every queued result come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_ham.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- result side

    // output pacing: random ready bursts, one long hold-off once HOLD_AT points have gone in
    initial begin : out_pacing
        int stall;
        i_out_ready  <= 1'b0;
        longest_hold = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            if (longest_hold < LONG_HOLD && pts_in >= HOLD_AT)
                stall = LONG_HOLD;
            else
                stall = pick_gap(rx_steady);
            if (stall > longest_hold)
                longest_hold = stall;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // compare each result beat with the oldest queued expectation
    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            res_cnt++;
            if (pending_ham.size() == 0) begin
                $display("%0t: result beat with no point pending, expected none, got ham %0d",
                         $time, o_out_beat.ham_value);
                err_cnt++;
            end else begin
                want = pending_ham.pop_front();
                if (o_out_beat.ham_value !== want.ham_value) begin
                    $display("%0t: ham_value mismatch, expected %0d, got %0d",
                             $time, want.ham_value, o_out_beat.ham_value);
                    err_cnt++;
                end
                if (o_out_beat.chunk_end_out !== want.chunk_end_out) begin
                    $display("%0t: chunk_end_out mismatch, expected %0b, got %0b",
                             $time, want.chunk_end_out, o_out_beat.chunk_end_out);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog: too long without any beat on any channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial begin : main_seq
        t_row row;
        err_cnt      = 0;
        pts_in       = 0;
        res_cnt      = 0;
        cfg_cnt      = 0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        // shadow starts at the reset values
        sh_speed_min = 256;
        sh_speed_max = 256;
        sh_turn_max  = 256;
        sh_dist_x    = 0;
        sh_dist_y    = 0;
        sh_ctrl_max  = 1'b1;
        sh_dist_min  = 1'b1;
        sh_backward  = 1'b1;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_beat   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SPEED_MIN;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed points under reset values, no register written yet
        for (int k = 0; k < N_DIRECTED; k++) begin
            row = directed_row(k);
            drive_point(row.pt, row.typed, row.ham);
        end
        drain();

        // random points, one register setting per phase, written only with the pipe empty
        for (int ph = 0; ph < N_PHASES; ph++) begin
            program_regs(phase_regs(ph));
            tx_steady = (ph % 4 == 1);
            rx_steady = (ph % 4 == 1);
            for (int k = 0; k < PTS_PER_PHASE; k++)
                drive_point(random_point(), 1'b0, '0);
            drain();
        end

        // nothing pending: give a stray beat time to show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_ham.size() != 0) begin
            $display("%0t: %0d results never arrived, expected %0d, got 0",
                     $time, pending_ham.size(), pending_ham.size());
            err_cnt++;
        end

        $display("covered %0d points (%0d directed), %0d results, %0d register writes",
                 pts_in, N_DIRECTED, res_cnt, cfg_cnt);
        $display("over %0d register settings, longest output hold-off %0d cycles",
                 N_PHASES + 1, longest_hold);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: plane_hamiltonian_point.f
sv/plnh_pkg.sv
sv/plnh_cordic.sv
sv/plane_hamiltonian_point.sv
bench/plane_hamiltonian_point_tb.sv
